// ----- src/ocq_pkg.sv -----
// ocq_pkg: shared types and codes for the outline to quadratic curves block
// used by ocq_scale, ocq_emit and outline_to_quadratic_curves_core
package ocq_pkg;

  localparam int RAW_W   = 16;
  localparam int SCALE_W = 32;
  localparam int PT_W    = 48;
  localparam int OUT_W   = 54;

  localparam logic [2:0] ACT_MOVE  = 3'd0;
  localparam logic [2:0] ACT_LINE  = 3'd1;
  localparam logic [2:0] ACT_QUAD  = 3'd2;
  localparam logic [2:0] ACT_CUBIC = 3'd3;
  localparam logic [2:0] ACT_END   = 3'd4;

  localparam logic [SCALE_W-1:0] EM_SCALE_RESET = 32'h0100_0000;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [PT_W-1:0]  pt_t;
  typedef logic signed [OUT_W-1:0] ocoord_t;

  typedef struct packed {
    logic [2:0] action;
    raw_t       x;
    raw_t       y;
    raw_t       c1x;
    raw_t       c1y;
    raw_t       c2x;
    raw_t       c2y;
  } raw_item_t;

  typedef struct packed {
    logic [2:0] action;
    pt_t        px;
    pt_t        py;
    pt_t        c1x;
    pt_t        c1y;
    pt_t        c2x;
    pt_t        c2y;
  } pts_item_t;

  typedef struct packed {
    ocoord_t start_x;
    ocoord_t start_y;
    ocoord_t control_x;
    ocoord_t control_y;
    ocoord_t end_x;
    ocoord_t end_y;
    logic    first_of_contour;
    logic    last;
  } seg_t;

endpackage

// ----- src/ocq_scale.sv -----
// ocq_scale: input register and em scale multiply stage
// depends on ocq_pkg
module ocq_scale (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [ocq_pkg::SCALE_W-1:0] em_scale,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  ocq_pkg::raw_item_t              up_item,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output ocq_pkg::pts_item_t              dn_item
);

  function automatic ocq_pkg::pt_t scale(input ocq_pkg::raw_t raw,
                                         input logic signed [ocq_pkg::SCALE_W-1:0] s);
    ocq_pkg::pt_t a;
    ocq_pkg::pt_t b;
    a = ocq_pkg::PT_W'(raw);
    b = ocq_pkg::PT_W'(s);
    return a * b;
  endfunction

  logic               s1_valid_r, s1_valid_nxt;
  ocq_pkg::raw_item_t s1_item_r;
  logic               s2_valid_r, s2_valid_nxt;
  ocq_pkg::pts_item_t s2_item_r, s2_item_nxt;
  logic               s2_free;
  logic               s1_free;

  assign s2_free  = !s2_valid_r || dn_ready;
  assign s1_free  = !s1_valid_r || s2_free;
  assign up_ready = s1_free;

  assign s1_valid_nxt = s1_free ? up_valid : s1_valid_r;
  assign s2_valid_nxt = s2_free ? s1_valid_r : s2_valid_r;

  always_comb begin
    s2_item_nxt.action = s1_item_r.action;
    s2_item_nxt.px     = scale(s1_item_r.x, em_scale);
    s2_item_nxt.py     = scale(s1_item_r.y, em_scale);
    s2_item_nxt.c1x    = scale(s1_item_r.c1x, em_scale);
    s2_item_nxt.c1y    = scale(s1_item_r.c1y, em_scale);
    s2_item_nxt.c2x    = scale(s1_item_r.c2x, em_scale);
    s2_item_nxt.c2y    = scale(s1_item_r.c2y, em_scale);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && up_valid) begin
      s1_item_r <= up_item;
    end
    if (s2_free && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_item  = s2_item_r;

endmodule

// ----- src/ocq_emit.sv -----
// ocq_emit: contour state, segment forming and the result register
// depends on ocq_pkg
module ocq_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  ocq_pkg::pts_item_t up_item,
  output logic               seg_valid,
  input  logic               seg_ready,
  output ocq_pkg::seg_t      seg
);

  function automatic ocq_pkg::ocoord_t ext(input ocq_pkg::pt_t v);
    return ocq_pkg::OUT_W'(v);
  endfunction

  ocq_pkg::pt_t  cur_x_r, cur_y_r, start_x_r, start_y_r;
  ocq_pkg::pt_t  cur_x_nxt, cur_y_nxt, start_x_nxt, start_y_nxt;
  logic          in_contour_r, in_contour_nxt;
  logic          has_curves_r, has_curves_nxt;
  logic          phase_r, phase_nxt;
  logic          out_valid_r, out_valid_nxt;
  ocq_pkg::seg_t out_seg_r, seg_nxt;

  logic          do_close, need_out, need_two, out_free, consume, emit;
  ocq_pkg::ocoord_t e0x, e0y, e1x, e1y, e2x, e2y, e3x, e3y, esx, esy;
  ocq_pkg::ocoord_t mid_x, mid_y, lft_x, lft_y, rgt_x, rgt_y;

  assign e0x = ext(cur_x_r);
  assign e0y = ext(cur_y_r);
  assign e1x = ext(up_item.c1x);
  assign e1y = ext(up_item.c1y);
  assign e2x = ext(up_item.c2x);
  assign e2y = ext(up_item.c2y);
  assign e3x = ext(up_item.px);
  assign e3y = ext(up_item.py);
  assign esx = ext(start_x_r);
  assign esy = ext(start_y_r);

  // de casteljau split at t = 1/2, exact in 2^-29 units
  assign mid_x = (e0x + 3 * e1x + 3 * e2x + e3x) <<< 2;
  assign mid_y = (e0y + 3 * e1y + 3 * e2y + e3y) <<< 2;
  assign lft_x = 9 * e0x + 21 * e1x + 3 * e2x - e3x;
  assign lft_y = 9 * e0y + 21 * e1y + 3 * e2y - e3y;
  assign rgt_x = 3 * e1x + 21 * e2x + 9 * e3x - e0x;
  assign rgt_y = 3 * e1y + 21 * e2y + 9 * e3y - e0y;

  assign do_close = in_contour_r && has_curves_r &&
                    (cur_x_r != start_x_r || cur_y_r != start_y_r);

  always_comb begin
    need_out = 1'b0;
    need_two = 1'b0;
    seg_nxt  = '0;
    unique case (up_item.action)
      ocq_pkg::ACT_MOVE, ocq_pkg::ACT_END: begin
        need_out = do_close;
        seg_nxt  = '{e0x <<< 5, e0y <<< 5, (e0x + esx) <<< 4, (e0y + esy) <<< 4,
                     esx <<< 5, esy <<< 5, 1'b0, 1'b1};
      end
      ocq_pkg::ACT_LINE: begin
        need_out = in_contour_r;
        seg_nxt  = '{e0x <<< 5, e0y <<< 5, (e0x + e3x) <<< 4, (e0y + e3y) <<< 4,
                     e3x <<< 5, e3y <<< 5, !has_curves_r, 1'b1};
      end
      ocq_pkg::ACT_QUAD: begin
        need_out = in_contour_r;
        seg_nxt  = '{e0x <<< 5, e0y <<< 5, e1x <<< 5, e1y <<< 5,
                     e3x <<< 5, e3y <<< 5, !has_curves_r, 1'b1};
      end
      ocq_pkg::ACT_CUBIC: begin
        need_out = in_contour_r;
        need_two = in_contour_r;
        if (!phase_r) begin
          seg_nxt = '{e0x <<< 5, e0y <<< 5, lft_x, lft_y, mid_x, mid_y,
                      !has_curves_r, 1'b0};
        end else begin
          seg_nxt = '{mid_x, mid_y, rgt_x, rgt_y, e3x <<< 5, e3y <<< 5, 1'b0, 1'b1};
        end
      end
      default: begin
        need_out = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_r || seg_ready;
  // a cubic holds its item for a second beat
  assign up_ready = !need_out || (out_free && !(need_two && !phase_r));
  assign consume  = up_valid && up_ready;
  assign emit     = up_valid && need_out && out_free;

  assign out_valid_nxt = emit ? 1'b1 : (seg_ready ? 1'b0 : out_valid_r);
  assign phase_nxt     = (emit && need_two) ? !phase_r : phase_r;

  always_comb begin
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    in_contour_nxt = in_contour_r;
    has_curves_nxt = has_curves_r;
    if (consume) begin
      unique case (up_item.action)
        ocq_pkg::ACT_MOVE: begin
          cur_x_nxt      = up_item.px;
          cur_y_nxt      = up_item.py;
          start_x_nxt    = up_item.px;
          start_y_nxt    = up_item.py;
          in_contour_nxt = 1'b1;
          has_curves_nxt = 1'b0;
        end
        ocq_pkg::ACT_LINE, ocq_pkg::ACT_QUAD, ocq_pkg::ACT_CUBIC: begin
          if (in_contour_r) begin
            cur_x_nxt      = up_item.px;
            cur_y_nxt      = up_item.py;
            has_curves_nxt = 1'b1;
          end
        end
        ocq_pkg::ACT_END: begin
          cur_x_nxt      = '0;
          cur_y_nxt      = '0;
          start_x_nxt    = '0;
          start_y_nxt    = '0;
          in_contour_nxt = 1'b0;
          has_curves_nxt = 1'b0;
        end
        default: begin
          in_contour_nxt = in_contour_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      in_contour_r <= 1'b0;
      has_curves_r <= 1'b0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      in_contour_r <= in_contour_nxt;
      has_curves_r <= has_curves_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_seg_r <= seg_nxt;
    end
  end

  assign seg_valid = out_valid_r;
  assign seg       = out_seg_r;

endmodule

// ----- src/outline_to_quadratic_curves_core.sv -----
// outline_to_quadratic_curves_core: top level of the outline to quadratic curves block
// depends on ocq_pkg, ocq_scale and ocq_emit
//
// Usage:
//   in_*  : one outline vertex per beat; in_tuser carries the action code
//           (move, line, quadratic, cubic, end of outline), in_tdata the six
//           raw coordinates
//   out_* : one quadratic segment per beat, coordinates in 2^-29 em units;
//           out_tuser marks the first segment of a contour, out_tlast the
//           last segment caused by one vertex
//   cfg_* : write of the signed em scale (value / 2^24), only while idle
// Path: a vertex that yields a segment passes the input register (loaded on
//   the beat's own edge), the scale multiply register and the result
//   register before out_tvalid rises; the second segment of a cubic follows
//   when out_tready is high.
// Throughput: one vertex per cycle while out_tready stays high; a cubic holds
//   the result stage as it yields two segments through the single result register.
// Reset: synchronous, active low; contour state clears, em scale returns to
//   1.0 (2^24), the pipeline empties.
// Stall: with out_tready low the result register holds and back pressure
//   fills the two upstream stages before in_tready drops.
module outline_to_quadratic_curves_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] x_raw, [31:16] y_raw, [47:32] ctrl1_x_raw, [63:48] ctrl1_y_raw,
  // [79:64] ctrl2_x_raw, [95:80] ctrl2_y_raw
  input  logic [95:0]  in_tdata,
  // [2:0] action
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [53:0] start_x, [107:54] start_y, [161:108] control_x,
  // [215:162] control_y, [269:216] end_x, [323:270] end_y, [327:324] zero
  output logic [327:0] out_tdata,
  // [0] first_of_contour
  output logic [0:0]   out_tuser,
  output logic         out_tlast
);

  logic signed [ocq_pkg::SCALE_W-1:0] em_scale_r;
  ocq_pkg::raw_item_t                 in_item;
  logic                               pts_valid, pts_ready;
  ocq_pkg::pts_item_t                 pts_item;
  ocq_pkg::seg_t                      seg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_scale_r <= ocq_pkg::EM_SCALE_RESET;
    end else if (cfg_we) begin
      em_scale_r <= cfg_wdata;
    end
  end

  assign in_item.action = in_tuser;
  assign in_item.x      = in_tdata[15:0];
  assign in_item.y      = in_tdata[31:16];
  assign in_item.c1x    = in_tdata[47:32];
  assign in_item.c1y    = in_tdata[63:48];
  assign in_item.c2x    = in_tdata[79:64];
  assign in_item.c2y    = in_tdata[95:80];

  ocq_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .em_scale (em_scale_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_item  (in_item),
    .dn_valid (pts_valid),
    .dn_ready (pts_ready),
    .dn_item  (pts_item)
  );

  ocq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (pts_valid),
    .up_ready  (pts_ready),
    .up_item   (pts_item),
    .seg_valid (out_tvalid),
    .seg_ready (out_tready),
    .seg       (seg)
  );

  assign out_tdata = {4'b0, seg.end_y, seg.end_x, seg.control_y, seg.control_x,
                      seg.start_y, seg.start_x};
  assign out_tuser = seg.first_of_contour;
  assign out_tlast = seg.last;

endmodule
